// ===== design/atan2pa_pkg.sv =====
// ----------------------------------------------------------------------------
// atan2pa_pkg
// Shared types, widths and fixed-point constants of the atan2 angle pipeline.
// ----------------------------------------------------------------------------
package atan2pa_pkg;

  localparam int INPUT_WIDTH_DEF = 16;

  // ratio a = min/max, unsigned Q1.16 in [0, 1], the integer bit only for exactly one
  localparam int FRAC_W  = 16;
  localparam int RATIO_W = FRAC_W + 1;
  localparam int Q16_W   = 18;
  localparam int PROD_W  = 2 * Q16_W;
  localparam int ANG_W   = 19;
  localparam int ANGLE_W = 16;

  typedef logic        [RATIO_W-1:0] ratio_t;
  typedef logic signed [Q16_W-1:0]   q16_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ANG_W-1:0]   ang_t;
  typedef logic        [ANGLE_W-1:0] q13_t;

  // octant of the input vector, carried alongside the data
  typedef struct packed {
    logic swap;   // |y| > |x|
    logic xneg;
    logic yneg;
  } oct_t;

  localparam ratio_t ONE_Q16   = 17'd65536;
  localparam q16_t   C3_Q16    = -18'sd3047;
  localparam q16_t   C2_Q16    = 18'sd10441;
  localparam q16_t   C1_Q16    = -18'sd21471;
  localparam prod_t  HALF_Q16  = 36'sd32768;
  localparam ang_t   PI_2_Q16  = 19'sd102944;
  localparam ang_t   PI_Q16    = 19'sd205887;
  localparam ang_t   HALF_Q13  = 19'sd4;
  localparam q13_t   PI_Q13    = 16'd25736;

  // Q32 product back to Q16, round half up: floor((p + 2^15) / 2^16)
  function automatic q16_t rnd_q16(input prod_t p);
    prod_t w;
    w = p + HALF_Q16;
    return q16_t'(w[FRAC_W+Q16_W-1:FRAC_W]);
  endfunction

endpackage

// ===== design/atan2_polynomial_angle.sv =====
// ----------------------------------------------------------------------------
// atan2_polynomial_angle
// Streaming atan2(y, x) in Q3.13 radians by ratio division and odd polynomial.
// ----------------------------------------------------------------------------
// Takes one vector per clock while the output is not stalled and returns one
// angle per vector, in order. The stages are one input stage (magnitudes and
// octant), a 17-stage restoring divider producing one quotient bit per stage,
// five polynomial stages with one multiplier each, and two fold and rounding
// stages ending in the output register. Stalls back-pressure stage by stage,
// so empty stages fill up before in_tready drops. A zero vector gives angle
// 0; the result is saturated to plus or minus pi (25736).
module atan2_polynomial_angle #(
  parameter int INPUT_WIDTH = atan2pa_pkg::INPUT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [INPUT_WIDTH-1:0] vec_x, [2*INPUT_WIDTH-1:INPUT_WIDTH] vec_y, rest zero
  input  logic [((2*INPUT_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] angle
  output logic [atan2pa_pkg::ANGLE_W-1:0]      out_tdata
);

  logic [INPUT_WIDTH-1:0] vec_x, vec_y, ax, ay;
  logic                   swap;
  logic                   vld_r;
  logic                   rdy0;
  logic [INPUT_WIDTH-1:0] mn_r, mx_r;
  atan2pa_pkg::oct_t      oct_r;

  logic                   div_ready, div_valid;
  atan2pa_pkg::ratio_t    div_quo;
  atan2pa_pkg::oct_t      div_oct;
  logic                   poly_ready, poly_valid;
  atan2pa_pkg::ratio_t    poly_r;
  atan2pa_pkg::oct_t      poly_oct;
  logic                   fold_ready;

  assign vec_x = in_tdata[INPUT_WIDTH-1:0];
  assign vec_y = in_tdata[2*INPUT_WIDTH-1:INPUT_WIDTH];
  assign ax    = vec_x[INPUT_WIDTH-1] ? INPUT_WIDTH'(~vec_x + 1'b1) : vec_x;
  assign ay    = vec_y[INPUT_WIDTH-1] ? INPUT_WIDTH'(~vec_y + 1'b1) : vec_y;
  assign swap  = ay > ax;

  assign rdy0      = ~vld_r | div_ready;
  assign in_tready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy0) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_tvalid) begin
      mn_r       <= swap ? ax : ay;
      mx_r       <= swap ? ay : ax;
      oct_r.swap <= swap;
      oct_r.xneg <= vec_x[INPUT_WIDTH-1];
      oct_r.yneg <= vec_y[INPUT_WIDTH-1];
    end
  end

  atan2pa_div #(
    .MAG_W (INPUT_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_r),
    .in_ready  (div_ready),
    .in_num    (mn_r),
    .in_den    (mx_r),
    .in_oct    (oct_r),
    .out_valid (div_valid),
    .out_ready (poly_ready),
    .out_quo   (div_quo),
    .out_oct   (div_oct)
  );

  atan2pa_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ready  (poly_ready),
    .in_a      (div_quo),
    .in_oct    (div_oct),
    .out_valid (poly_valid),
    .out_ready (fold_ready),
    .out_r     (poly_r),
    .out_oct   (poly_oct)
  );

  atan2pa_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (poly_valid),
    .in_ready  (fold_ready),
    .in_r      (poly_r),
    .in_oct    (poly_oct),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_angle (out_tdata)
  );

`ifndef NO_ASSERTIONS
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= $signed(atan2pa_pkg::PI_Q13) &&
                    $signed(out_tdata) >= -$signed(atan2pa_pkg::PI_Q13)))
    else $error("angle outside plus or minus pi");
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while output side is free");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

// ===== design/atan2pa_div.sv =====
// ----------------------------------------------------------------------------
// atan2pa_div
// Pipelined restoring divider: quotient (num << 16) / den, one bit per stage.
// num <= den is assumed, so the quotient fits in 17 bits; den of zero gives 0.
// ----------------------------------------------------------------------------
module atan2pa_div #(
  parameter int MAG_W = atan2pa_pkg::INPUT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [MAG_W-1:0]            in_num,
  input  logic [MAG_W-1:0]            in_den,
  input  atan2pa_pkg::oct_t           in_oct,
  output logic                        out_valid,
  input  logic                        out_ready,
  output atan2pa_pkg::ratio_t         out_quo,
  output atan2pa_pkg::oct_t           out_oct
);

  localparam int NSTG  = atan2pa_pkg::RATIO_W;
  localparam int REM_W = MAG_W + 1;

  logic                      vld_r [0:NSTG-1];
  logic                      rdy   [0:NSTG];
  logic [REM_W-1:0]          rem_r [0:NSTG-2];
  logic [MAG_W-1:0]          den_r [0:NSTG-2];
  atan2pa_pkg::ratio_t       quo_r [0:NSTG-1];
  atan2pa_pkg::oct_t         oct_r [0:NSTG-1];

  assign rdy[NSTG] = out_ready;

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic                  vin;
    logic [REM_W-1:0]      rem_in;
    logic [MAG_W-1:0]      den_in;
    atan2pa_pkg::ratio_t   quo_in;
    atan2pa_pkg::oct_t     oct_in;
    logic                  ge;
    atan2pa_pkg::ratio_t   quo_nxt;

    if (k == 0) begin : g_first
      assign vin    = in_valid;
      assign rem_in = {1'b0, in_num};
      assign den_in = in_den;
      assign quo_in = '0;
      assign oct_in = in_oct;
    end else begin : g_next
      assign vin    = vld_r[k-1];
      assign rem_in = {rem_r[k-1][MAG_W-1:0], 1'b0};
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
      assign oct_in = oct_r[k-1];
    end

    assign ge      = (den_in != '0) && (rem_in >= {1'b0, den_in});
    assign quo_nxt = quo_in | ({{(NSTG-1){1'b0}}, ge} << (NSTG-1-k));
    assign rdy[k]  = ~vld_r[k] | rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vin) begin
        quo_r[k] <= quo_nxt;
        oct_r[k] <= oct_in;
      end
    end

    // the last stage keeps no remainder or divisor, only the quotient and octant
    if (k < NSTG - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (rdy[k] && vin) begin
          rem_r[k] <= ge ? (rem_in - {1'b0, den_in}) : rem_in;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTG-1];
  assign out_quo   = quo_r[NSTG-1];
  assign out_oct   = oct_r[NSTG-1];

`ifndef NO_ASSERTIONS
  a_quo_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quo <= atan2pa_pkg::ONE_Q16))
    else $error("divider quotient above one");
`endif

endmodule

// ===== design/atan2pa_poly.sv =====
// ----------------------------------------------------------------------------
// atan2pa_poly
// Odd polynomial r = a + a*s*(C1 + s*(C2 + C3*s)), s = a*a, in Q0.16.
// Five stages, one multiplier and one rounding add in each.
// ----------------------------------------------------------------------------
module atan2pa_poly (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  atan2pa_pkg::ratio_t  in_a,
  input  atan2pa_pkg::oct_t    in_oct,
  output logic                 out_valid,
  input  logic                 out_ready,
  output atan2pa_pkg::ratio_t  out_r,
  output atan2pa_pkg::oct_t    out_oct
);

  localparam int NSTG   = 5;
  localparam int Q_SIGN = atan2pa_pkg::Q16_W - 1;

  logic [NSTG-1:0]     vld_r;
  logic [NSTG-1:0]     rdy;
  logic [NSTG-1:0]     vin;
  atan2pa_pkg::oct_t   oct_r [0:NSTG-1];
  atan2pa_pkg::q16_t   a_r   [0:NSTG-2];
  atan2pa_pkg::q16_t   s_r   [0:NSTG-3];
  atan2pa_pkg::q16_t   t_r   [1:NSTG-2];
  atan2pa_pkg::ratio_t r_r;

  atan2pa_pkg::q16_t   a_in;
  atan2pa_pkg::prod_t  p0, p1, p2, p3, p4;
  atan2pa_pkg::q16_t   s_nxt, t1_nxt, t2_nxt, t3_nxt, r_raw;

  always_comb begin
    rdy[NSTG-1] = ~vld_r[NSTG-1] | out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
  end

  assign vin = {vld_r[NSTG-2:0], in_valid};

  assign a_in   = atan2pa_pkg::q16_t'({1'b0, in_a});
  assign p0     = a_in * a_in;
  assign s_nxt  = atan2pa_pkg::rnd_q16(p0);
  assign p1     = atan2pa_pkg::C3_Q16 * s_r[0];
  assign t1_nxt = atan2pa_pkg::rnd_q16(p1) + atan2pa_pkg::C2_Q16;
  assign p2     = t_r[1] * s_r[1];
  assign t2_nxt = atan2pa_pkg::rnd_q16(p2) + atan2pa_pkg::C1_Q16;
  assign p3     = t_r[2] * s_r[2];
  assign t3_nxt = atan2pa_pkg::rnd_q16(p3);
  assign p4     = t_r[3] * a_r[3];
  assign r_raw  = atan2pa_pkg::rnd_q16(p4) + a_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && vin[0]) begin
      a_r[0]   <= a_in;
      s_r[0]   <= s_nxt;
      oct_r[0] <= in_oct;
    end
    if (rdy[1] && vin[1]) begin
      a_r[1]   <= a_r[0];
      s_r[1]   <= s_r[0];
      t_r[1]   <= t1_nxt;
      oct_r[1] <= oct_r[0];
    end
    if (rdy[2] && vin[2]) begin
      a_r[2]   <= a_r[1];
      s_r[2]   <= s_r[1];
      t_r[2]   <= t2_nxt;
      oct_r[2] <= oct_r[1];
    end
    if (rdy[3] && vin[3]) begin
      a_r[3]   <= a_r[2];
      t_r[3]   <= t3_nxt;
      oct_r[3] <= oct_r[2];
    end
    if (rdy[4] && vin[4]) begin
      // negative correction clamps to zero
      r_r      <= r_raw[Q_SIGN] ? '0 : atan2pa_pkg::ratio_t'(r_raw[atan2pa_pkg::RATIO_W-1:0]);
      oct_r[4] <= oct_r[3];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTG-1];
  assign out_r     = r_r;
  assign out_oct   = oct_r[NSTG-1];

`ifndef NO_ASSERTIONS
  a_r_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_r <= atan2pa_pkg::ONE_Q16))
    else $error("polynomial result above one");
`endif

endmodule

// ===== design/atan2pa_fold.sv =====
// ----------------------------------------------------------------------------
// atan2pa_fold
// Octant fold of the first-octant angle, rounding to Q3.13, saturation to pi
// and sign. Two stages; the second is the output register.
// ----------------------------------------------------------------------------
module atan2pa_fold (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  atan2pa_pkg::ratio_t  in_r,
  input  atan2pa_pkg::oct_t    in_oct,
  output logic                 out_valid,
  input  logic                 out_ready,
  output atan2pa_pkg::q13_t    out_angle
);

  logic               vld0_r, vld1_r;
  logic               rdy0, rdy1;
  atan2pa_pkg::ang_t  f_r;
  logic               yneg_r;
  atan2pa_pkg::q13_t  angle_r;

  atan2pa_pkg::ang_t  rr, f1, f2, f_nxt, sum;
  atan2pa_pkg::q13_t  mag, mag_sat;

  assign rdy1 = ~vld1_r | out_ready;
  assign rdy0 = ~vld0_r | rdy1;

  always_comb begin
    rr    = atan2pa_pkg::ang_t'({2'b00, in_r});
    f1    = in_oct.swap ? (atan2pa_pkg::PI_2_Q16 - rr) : rr;
    f2    = in_oct.xneg ? (atan2pa_pkg::PI_Q16 - f1) : f1;
    f_nxt = f2[atan2pa_pkg::ANG_W-1] ? '0 : f2;
  end

  always_comb begin
    sum     = f_r + atan2pa_pkg::HALF_Q13;
    mag     = sum[atan2pa_pkg::ANG_W-1:3];
    mag_sat = (mag > atan2pa_pkg::PI_Q13) ? atan2pa_pkg::PI_Q13 : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
    end else begin
      if (rdy0) begin
        vld0_r <= in_valid;
      end
      if (rdy1) begin
        vld1_r <= vld0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      f_r    <= f_nxt;
      yneg_r <= in_oct.yneg;
    end
    if (rdy1 && vld0_r) begin
      angle_r <= yneg_r ? (~mag_sat + 1'b1) : mag_sat;
    end
  end

  assign in_ready  = rdy0;
  assign out_valid = vld1_r;
  assign out_angle = angle_r;

endmodule

// ===== test/atan2_polynomial_angle_tb.sv =====
// ----------------------------------------------------------------------------
// atan2_polynomial_angle_tb
// Stream test of the atan2 angle pipeline against a fixed-point predictor.
// ----------------------------------------------------------------------------
// Vectors go in as bursts with random gaps. The receiver stalls in changing
// patterns and once holds off long enough to back the pipeline up to its
// input. Every angle that comes out is checked in order against the angle
// predicted for the vector at the time of its input transfer.
module atan2_polynomial_angle_tb;

  localparam int INPUT_WIDTH  = 16;
  localparam int TDATA_W      = ((2 * INPUT_WIDTH + 7) / 8) * 8;
  localparam int ANGLE_W      = atan2pa_pkg::ANGLE_W;
  localparam int RANDOM_ITEMS = 1300;
  localparam int PIPE_LATENCY = 25;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  // Fixed-point angle predictor and the in-order store of expected angles.
  class angle_scoreboard;
    localparam longint POLY_C3  = -3047;
    localparam longint POLY_C2  = 10441;
    localparam longint POLY_C1  = -21471;
    localparam longint HALF_PI  = 102944;
    localparam longint FULL_PI  = 205887;
    localparam longint PI_Q13   = 25736;

    logic [ANGLE_W-1:0] expected_angles[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Q32 to Q16, round half up (floor division by arithmetic shift)
    function longint round_q16(longint p);
      return (p + 64'sd32768) >>> 16;
    endfunction

    function logic [ANGLE_W-1:0] predict_angle(logic signed [INPUT_WIDTH-1:0] vx,
                                               logic signed [INPUT_WIDTH-1:0] vy);
      longint x, y, ax, ay, mn, mx, a, s, t, r, q;
      x  = longint'(vx);
      y  = longint'(vy);
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      mn = (ax < ay) ? ax : ay;
      mx = (ax < ay) ? ay : ax;
      a  = (mx == 0) ? 0 : ((mn << 16) / mx);
      s  = round_q16(a * a);
      t  = round_q16(POLY_C3 * s) + POLY_C2;
      t  = round_q16(t * s) + POLY_C1;
      t  = round_q16(t * s);
      r  = round_q16(t * a) + a;
      if (r < 0) r = 0;
      if (ay > ax) r = HALF_PI - r;
      if (x < 0) r = FULL_PI - r;
      if (r < 0) r = 0;
      q = (r + 4) >>> 3;
      if (q > PI_Q13) q = PI_Q13;
      if (y < 0) q = -q;
      return q[ANGLE_W-1:0];
    endfunction

    function void note_vector(logic signed [INPUT_WIDTH-1:0] vx,
                              logic signed [INPUT_WIDTH-1:0] vy);
      expected_angles.push_back(predict_angle(vx, vy));
    endfunction

    function void check_angle(logic [ANGLE_W-1:0] actual);
      logic [ANGLE_W-1:0] exp_angle;
      if (expected_angles.size() == 0) begin
        $error("angle: unexpected transfer, actual %0d", $signed(actual));
        errors++;
      end else begin
        exp_angle = expected_angles.pop_front();
        if (actual !== exp_angle) begin
          $error("angle mismatch: expected %0d, actual %0d",
                 $signed(exp_angle), $signed(actual));
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_angles.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;   // [15:0] vec_x, [31:16] vec_y
  logic               out_tvalid;
  logic               out_tready;
  logic [ANGLE_W-1:0] out_tdata;  // [15:0] angle

  logic hold_request = 1'b0;
  int   cycle_count  = 0;

  angle_scoreboard sb = new();

  // x, y pairs: zero vector, axes, corners, x negative with y zero,
  // equal magnitudes, near-diagonal and tiny ratios
  int dir_x [24] = '{0, 32767, -32768, 0, 0, -32768, 32767, -1, -32768, -1,
                     1, -1, 1, -1, 32767, -32768, 100, 99, 12345, -5,
                     0, 1, -32768, 2};
  int dir_y [24] = '{0, 0, 0, 32767, -32768, -32768, 32767, 0, -1, -32768,
                     1, 1, -1, -1, -32768, 32767, 99, 100, -12345, 0,
                     -1, 0, 1, 1};

  always #4 clk = ~clk;

  atan2_polynomial_angle #(.INPUT_WIDTH(INPUT_WIDTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_angle(out_tdata);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL atan2_polynomial_angle");
      $finish;
    end
  end

  // Receiver: stall pattern is drawn anew at random intervals; a hold request
  // parks out_tready low for a long stretch, once.
  initial begin : receiver
    rx_mode_e mode;
    int       mode_left;
    int       phase;
    bit       held;
    mode       = RX_ALWAYS;
    mode_left  = 0;
    phase      = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        held = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_ALWAYS:   out_tready = 1'b1;
          RX_RANDOM:   out_tready = ($urandom_range(0, 1) == 1);
          RX_PERIODIC: out_tready = (phase % 5) < 3;
          default:     out_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_vector(input logic signed [INPUT_WIDTH-1:0] vx,
                             input logic signed [INPUT_WIDTH-1:0] vy);
    in_tdata  = {vy, vx};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_vector(vx, vy);
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_tvalid = 1'b0;
      in_tdata  = $urandom;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  task automatic random_vector(output logic signed [INPUT_WIDTH-1:0] vx,
                               output logic signed [INPUT_WIDTH-1:0] vy);
    int corner [6] = '{-32768, -32767, -1, 0, 1, 32767};
    logic signed [INPUT_WIDTH-1:0] m;
    int d;
    m = INPUT_WIDTH'($urandom);
    d = $urandom_range(0, 6);
    d = d - 3;
    case ($urandom_range(0, 9))
      4: begin
        vx = INPUT_WIDTH'($urandom_range(0, 16) - 8);
        vy = INPUT_WIDTH'($urandom_range(0, 16) - 8);
      end
      5: begin
        // magnitudes equal or nearly so
        vx = m;
        vy = INPUT_WIDTH'(($urandom_range(0, 1) ? m : -m) + d);
      end
      6: begin
        vx = INPUT_WIDTH'($urandom);
        vy = INPUT_WIDTH'($urandom);
        if ($urandom_range(0, 1)) vx = 0;
        else vy = 0;
      end
      7: begin
        vx = INPUT_WIDTH'(corner[$urandom_range(0, 5)]);
        vy = INPUT_WIDTH'(corner[$urandom_range(0, 5)]);
      end
      8: begin
        // tiny ratio, either way round
        vx = m;
        vy = INPUT_WIDTH'(d);
        if ($urandom_range(0, 1)) begin
          vx = INPUT_WIDTH'(d);
          vy = m;
        end
      end
      default: begin
        vx = INPUT_WIDTH'($urandom);
        vy = INPUT_WIDTH'($urandom);
      end
    endcase
  endtask

  initial begin : stimulus
    logic signed [INPUT_WIDTH-1:0] vx, vy;
    int sent;
    int burst_left;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    idle_cycles(3);

    for (int i = 0; i < 24; i++) begin
      send_vector(INPUT_WIDTH'(dir_x[i]), INPUT_WIDTH'(dir_y[i]));
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 4));
    end
    wait_drained();

    sent       = 0;
    burst_left = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 400) begin
        // receiver parks while a long gapless burst fills the pipeline
        hold_request = 1'b1;
        burst_left   = 150;
      end else if (sent == 800) begin
        wait_drained();
      end
      if (burst_left == 0) begin
        idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
        burst_left = $urandom_range(1, 48);
      end
      random_vector(vx, vy);
      send_vector(vx, vy);
      sent++;
      burst_left--;
    end

    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2 * PIPE_LATENCY) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS atan2_polynomial_angle");
    end else begin
      $display("FAIL atan2_polynomial_angle");
    end
    $finish;
  end

endmodule
